>>> hdl/trm_pkg.sv
`default_nettype none

package trm_pkg;

  // Fixed field widths
  localparam int DATA_W = 32;
  localparam int KEY_W  = 32;

  // Default trie geometry
  localparam int NODE_BITS_DEF = 4;
  localparam int NODE_POOL_DEF = 256;
  localparam int KEY_BITS_DEF  = 32;

  // Operation codes
  localparam logic FUNC_SEARCH = 1'b0;
  localparam logic FUNC_INSERT = 1'b1;

  // Result status codes
  localparam logic STAT_DONE = 1'b0;
  localparam logic STAT_FULL = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_ALLOC,
    ST_DONE
  } trm_state_e;

  // Node store access command
  typedef struct packed {
    logic rd;
    logic wr;
  } trm_mem_cmd_t;

  // Finished result of one operation
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              full;
  } trm_result_t;

endpackage

`default_nettype wire

>>> hdl/radix_trie_map_32.sv
`default_nettype none

// Radix trie map: 32-bit keys to nonzero 32-bit values. The key is cut into
// NODE_BITS-bit digits, most significant first; each digit picks one child
// slot of a node held in a single-port node store of NODE_POOL * 2**NODE_BITS
// words with a registered read. func 0 searches and returns the value or
// 0; func 1 inserts, allocating nodes from a pool that is never freed, and
// returns the previous value; status 1 means the pool could not supply the
// nodes the path needs and nothing changed. After reset the store is swept
// to zero, one word a cycle, before the first transfer is taken. One
// operation is handled at a time: the input transfer reads the root slot,
// each ST_WALK step takes the read of one level and issues the next, and
// ST_DONE then raises result valid; the next input transfer is taken once
// the result has moved on. An insert that has to allocate nodes links one
// fresh node per new level in ST_ALLOC and then writes the leaf; a search
// whose path ends early or a refused insert finishes sooner. A finished
// result waits in an output register while the next operation is taken.
module radix_trie_map_32 #(
  parameter int NODE_BITS = trm_pkg::NODE_BITS_DEF,
  parameter int NODE_POOL = trm_pkg::NODE_POOL_DEF,
  parameter int KEY_BITS  = trm_pkg::KEY_BITS_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // input stream
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [63:0] s_axis_tdata,  // [31:0] key, [63:32] value
  input  wire  [0:0]  s_axis_tuser,  // [0] func
  // result stream
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [31:0] value_out
  output logic [0:0]  m_axis_tuser   // [0] status
);
  import trm_pkg::*;

  localparam int AW = $clog2(NODE_POOL) + NODE_BITS;

  trm_mem_cmd_t      mem_cmd;
  logic [AW-1:0]     mem_addr;
  logic [DATA_W-1:0] mem_wdata;
  logic [DATA_W-1:0] mem_rdata;
  logic              res_valid;
  logic              res_ready;
  trm_result_t       res;
  logic              m_valid_q, m_valid_d;
  logic [DATA_W-1:0] m_data_q;
  logic              m_user_q;

  trm_ctrl #(
    .NODE_BITS (NODE_BITS),
    .NODE_POOL (NODE_POOL),
    .KEY_BITS  (KEY_BITS),
    .AW        (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .func_i      (s_axis_tuser[0]),
    .key_i       (s_axis_tdata[31:0]),
    .value_i     (s_axis_tdata[63:32]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_cmd_o   (mem_cmd),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  trm_store #(
    .AW (AW)
  ) u_store (
    .clk_i   (clk_i),
    .cmd_i   (mem_cmd),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // Output register: load when empty or draining
  assign res_ready = !m_valid_q || m_axis_tready;

  always_comb begin
    m_valid_d = m_valid_q;
    if (res_valid && res_ready) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      m_data_q <= res.value;
      m_user_q <= res.full;
    end
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_data_q;
  assign m_axis_tuser[0] = m_user_q;

`ifndef SYNTHESIS
  // A refused insert never reports a previous value
  a_full_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[0] == STAT_FULL) |-> m_axis_tdata == '0)
    else $error("refused insert carries a nonzero value");

  // One operation in flight: no transfer right after a transfer
  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an operation is in flight");

  // Single-port store: never read and write in one cycle
  a_one_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_cmd.rd && mem_cmd.wr))
    else $error("node store read and written in the same cycle");

  // A finished result is not lost while the output register is full
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid)
    else $error("pending result dropped");
`endif

endmodule

`default_nettype wire

>>> hdl/trm_store.sv
`default_nettype none

module trm_store #(
  parameter int AW = 12
) (
  input  wire                   clk_i,
  input  trm_pkg::trm_mem_cmd_t cmd_i,
  input  wire  [AW-1:0]         addr_i,
  input  wire  [trm_pkg::DATA_W-1:0] wdata_i,
  output logic [trm_pkg::DATA_W-1:0] rdata_o
);
  import trm_pkg::*;

  logic [DATA_W-1:0] mem_q [0:(2**AW)-1];

  // Write one slot
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

`default_nettype wire

>>> hdl/trm_ctrl.sv
`default_nettype none

module trm_ctrl #(
  parameter int NODE_BITS = trm_pkg::NODE_BITS_DEF,
  parameter int NODE_POOL = trm_pkg::NODE_POOL_DEF,
  parameter int KEY_BITS  = trm_pkg::KEY_BITS_DEF,
  parameter int AW        = $clog2(NODE_POOL) + NODE_BITS
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  // operation in
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  input  wire                         func_i,
  input  wire  [trm_pkg::KEY_W-1:0]   key_i,
  input  wire  [trm_pkg::DATA_W-1:0]  value_i,
  // result out
  output logic                        res_valid_o,
  input  wire                         res_ready_i,
  output trm_pkg::trm_result_t        res_o,
  // node store port
  output trm_pkg::trm_mem_cmd_t       mem_cmd_o,
  output logic [AW-1:0]               mem_addr_o,
  output logic [trm_pkg::DATA_W-1:0]  mem_wdata_o,
  input  wire  [trm_pkg::DATA_W-1:0]  mem_rdata_i
);
  import trm_pkg::*;

  localparam int LEVELS = (KEY_BITS + NODE_BITS - 1) / NODE_BITS;
  localparam int PW     = LEVELS * NODE_BITS;
  localparam int NW     = $clog2(NODE_POOL);
  localparam int NFW    = $clog2(NODE_POOL + 1);
  localparam int LCW    = $clog2(LEVELS) + 1;
  localparam int CW     = (NFW > LCW) ? NFW : LCW;
  localparam longint unsigned DEPTH = longint'(NODE_POOL) << NODE_BITS;
  localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

  trm_state_e          state_q, state_d;
  logic [LCW-1:0]      lvl_q, lvl_d;
  logic [NW-1:0]       node_q, node_d;
  logic [PW-1:0]       key_q, key_d;
  logic                func_q, func_d;
  logic [DATA_W-1:0]   val_q, val_d;
  logic [NFW-1:0]      nf_q, nf_d;
  logic [DATA_W-1:0]   res_q, res_d;
  logic                full_q, full_d;
  logic [AW-1:0]       clr_q, clr_d;

  logic [PW-1:0]        key_in;
  logic [PW-1:0]        key_nx;
  logic [NODE_BITS-1:0] digit;
  logic [NODE_BITS-1:0] digit_nx;
  logic [NODE_BITS-1:0] digit_in;
  logic                 last_lvl;
  logic                 child_ok;
  logic [NW-1:0]        child_node;
  logic [CW-1:0]        need_w;
  logic [CW-1:0]        free_w;
  logic                 refuse;

  // Digit extraction: the key register shifts up one digit per level
  assign key_in     = PW'(key_i[KEY_BITS-1:0]);
  assign key_nx     = key_q << NODE_BITS;
  assign digit      = key_q[PW-1 -: NODE_BITS];
  assign digit_nx   = key_nx[PW-1 -: NODE_BITS];
  assign digit_in   = key_in[PW-1 -: NODE_BITS];
  assign last_lvl   = (lvl_q == LCW'(LEVELS - 1));

  // Child slot check and pool room
  assign child_ok   = (mem_rdata_i != '0) && (mem_rdata_i < DATA_W'(NODE_POOL));
  assign child_node = mem_rdata_i[NW-1:0];
  assign need_w     = CW'(LEVELS - 1) - CW'(lvl_q);
  assign free_w     = CW'(NODE_POOL) - CW'(nf_q);
  assign refuse     = (need_w > free_w);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == CLR_LAST) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_WALK;
      end
      ST_WALK: begin
        if (last_lvl) begin
          state_d = ST_DONE;
        end else if (child_ok) begin
          state_d = ST_WALK;
        end else if (func_q == FUNC_INSERT && !refuse) begin
          state_d = ST_ALLOC;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_ALLOC: begin
        if (last_lvl) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    lvl_d       = lvl_q;
    node_d      = node_q;
    key_d       = key_q;
    func_d      = func_q;
    val_d       = val_q;
    nf_d        = nf_q;
    res_d       = res_q;
    full_d      = full_q;
    clr_d       = clr_q;
    mem_cmd_o   = '0;
    mem_addr_o  = {node_q, digit};
    mem_wdata_o = val_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        // sweep the node store to zero
        mem_cmd_o.wr = 1'b1;
        mem_addr_o   = clr_q;
        mem_wdata_o  = '0;
        clr_d        = clr_q + AW'(1);
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          // start at the root slot of the top digit
          mem_cmd_o.rd = 1'b1;
          mem_addr_o   = {NW'(0), digit_in};
          func_d       = func_i;
          key_d        = key_in;
          val_d        = value_i;
          lvl_d        = '0;
          node_d       = '0;
          full_d       = STAT_DONE;
        end
      end
      ST_WALK: begin
        if (last_lvl) begin
          // leaf slot: report it, replace it on insert
          res_d = mem_rdata_i;
          if (func_q == FUNC_INSERT) mem_cmd_o.wr = 1'b1;
        end else if (child_ok) begin
          // descend and read the next slot
          node_d       = child_node;
          lvl_d        = lvl_q + LCW'(1);
          key_d        = key_nx;
          mem_cmd_o.rd = 1'b1;
          mem_addr_o   = {child_node, digit_nx};
        end else begin
          res_d = '0;
          if (func_q == FUNC_INSERT && refuse) full_d = STAT_FULL;
        end
      end
      ST_ALLOC: begin
        mem_cmd_o.wr = 1'b1;
        if (last_lvl) begin
          // leaf of a fresh node held nothing before
          res_d = '0;
        end else begin
          // link a fresh node and step into it
          mem_wdata_o = DATA_W'(nf_q);
          node_d      = nf_q[NW-1:0];
          nf_d        = nf_q + NFW'(1);
          lvl_d       = lvl_q + LCW'(1);
          key_d       = key_nx;
        end
      end
      ST_DONE: begin
        res_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

  assign res_o.value = res_q;
  assign res_o.full  = full_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      nf_q    <= NFW'(1);
      clr_q   <= '0;
      lvl_q   <= '0;
      func_q  <= FUNC_SEARCH;
    end else begin
      state_q <= state_d;
      nf_q    <= nf_d;
      clr_q   <= clr_d;
      lvl_q   <= lvl_d;
      func_q  <= func_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    node_q <= node_d;
    key_q  <= key_d;
    val_q  <= val_d;
    res_q  <= res_d;
    full_q <= full_d;
  end

endmodule

`default_nettype wire
